>>> rtl/bfas_pkg.sv
// Package for the bit field access sequencer.
// Holds codes, field types and the access geometry helpers. No dependencies.
package bfas_pkg;

  localparam int unsigned MaxFieldBitsDef = 64;
  localparam int unsigned OffsetBitsDef   = 32;

  localparam logic [1:0] KIND_READ_REQ  = 2'd0;
  localparam logic [1:0] KIND_WRITE_REQ = 2'd1;
  localparam logic [1:0] KIND_RESPONSE  = 2'd2;
  localparam logic [1:0] KIND_IGNORED   = 2'd3;

  localparam logic [2:0] RK_BUS_READ   = 3'd0;
  localparam logic [2:0] RK_BUS_WRITE  = 3'd1;
  localparam logic [2:0] RK_READ_DONE  = 3'd2;
  localparam logic [2:0] RK_WRITE_DONE = 3'd3;
  localparam logic [2:0] RK_FAILED     = 3'd4;
  localparam logic [2:0] RK_BUSY       = 3'd5;

  localparam logic [1:0] REG_ACCESS_TYPE = 2'd0;
  localparam logic [1:0] REG_UPDATE_RULE = 2'd1;
  localparam logic [1:0] REG_REGION_BASE = 2'd2;

  localparam logic [1:0] UR_PRESERVE = 2'd0;
  localparam logic [1:0] UR_ONES     = 2'd1;

  localparam logic [2:0] AT_BYTE  = 3'd1;
  localparam logic [2:0] SIZE_BAD = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_READ     = 4'b0010,
    PH_PRESERVE = 4'b0100,
    PH_WRITE    = 4'b1000
  } phase_e;

  // One classified input item as it passes from front to back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] fld_offset;
    logic [7:0]  fld_count;
    logic [63:0] write_value;
    logic [63:0] response_data;
    logic        response_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [63:0] bus_address;
    logic [63:0] bus_data;
  } result_t;

  // log2 of access bytes; SIZE_BAD for buffer and undefined types.
  function automatic logic [2:0] size_log2(input logic [2:0] atype);
    logic [2:0] r;
    begin
      case (atype)
        3'd0, 3'd1: r = 3'd0;
        3'd2:       r = 3'd1;
        3'd3:       r = 3'd2;
        3'd4:       r = 3'd3;
        default:    r = SIZE_BAD;
      endcase
      return r;
    end
  endfunction

  function automatic logic [63:0] ones64(input logic [6:0] n);
    logic [63:0] r;
    begin
      if (n[6]) r = '1;
      else r = (64'd1 << n[5:0]) - 64'd1;
      return r;
    end
  endfunction

endpackage

>>> rtl/bit_field_access_sequencer.sv
// Top level of the bit field access sequencer.
// Depends on bfas_pkg, bfas_front and bfas_back.
//
// Turns a field read or write request into a run of aligned bus accesses of
// the configured access size; bus responses come back on the same input
// channel as kind 2 items and move the run on. The front pushes every
// accepted item but kind 3 into a two-entry queue; the back pops one item
// per cycle and writes at most one result into the output register, so the
// sustained rate is one item per clock while the output is drained. A result
// passes through the queue and the output register. The input stalls only
// while the queue is full, after an output stall. Configuration is
// written through the cfg channel, which is always ready; the back reads the
// registers at every step, so write them only while no item is in flight.
module bit_field_access_sequencer #(
  parameter int unsigned MaxFieldBits = bfas_pkg::MaxFieldBitsDef,
  parameter int unsigned OffsetBits   = bfas_pkg::OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] field_bit_offset_i,
  input  logic [7:0]  field_bit_count_i,
  input  logic [63:0] write_value_i,
  input  logic [63:0] response_data_i,
  input  logic        response_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [63:0] bus_address_o,
  output logic [63:0] bus_data_o
);
  logic [2:0]  access_type_q;
  logic [1:0]  update_rule_q;
  logic [63:0] region_base_q;
  logic              empty, pop, idle;
  bfas_pkg::item_t   head;
  bfas_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers; the back reads them at every step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_type_q <= bfas_pkg::AT_BYTE;
      update_rule_q <= bfas_pkg::UR_PRESERVE;
      region_base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bfas_pkg::REG_ACCESS_TYPE: access_type_q <= cfg_data_i[2:0];
        bfas_pkg::REG_UPDATE_RULE: update_rule_q <= cfg_data_i[1:0];
        bfas_pkg::REG_REGION_BASE: region_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bfas_front #(.OffsetBits(OffsetBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .field_bit_offset_i,
    .field_bit_count_i, .write_value_i, .response_data_i, .response_ok_i,
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  bfas_back #(.MaxFieldBits(MaxFieldBits)) u_back (
    .clk_i, .rst_ni,
    .access_type_i(access_type_q), .update_rule_i(update_rule_q),
    .region_base_i(region_base_q),
    .empty_i(empty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .res_o(res), .idle_o(idle)
  );

  assign result_kind_o = res.result_kind;
  assign bus_address_o = res.bus_address;
  assign bus_data_o    = res.bus_data;

  // Never pop into a full, stalled output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !pop) else $error("result overwritten");
  // Read-done and failed results leave the sequencer idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && (result_kind_o == bfas_pkg::RK_READ_DONE
      || result_kind_o == bfas_pkg::RK_FAILED) |-> idle)
    else $error("done without idle");
  // A bus access result always leaves a run in flight.
  a_bus_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && (result_kind_o == bfas_pkg::RK_BUS_READ
      || result_kind_o == bfas_pkg::RK_BUS_WRITE) |-> !idle)
    else $error("bus access while idle");
endmodule

>>> rtl/bfas_queue.sv
// Two-entry item queue between the front and back parts.
// Depends on bfas_pkg for the item type.
module bfas_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bfas_pkg::item_t  push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output bfas_pkg::item_t  head_o
);
  bfas_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end
endmodule

>>> rtl/bfas_front.sv
// Front part: accepts input items, drops idle kinds, queues the rest.
// Depends on bfas_pkg and bfas_queue.
module bfas_front #(
  parameter int unsigned OffsetBits = bfas_pkg::OffsetBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic [31:0]      field_bit_offset_i,
  input  logic [7:0]       field_bit_count_i,
  input  logic [63:0]      write_value_i,
  input  logic [63:0]      response_data_i,
  input  logic             response_ok_i,
  input  logic             pop_i,
  output logic             empty_o,
  output bfas_pkg::item_t  head_o
);
  logic            full;
  logic            push;
  bfas_pkg::item_t it;
  logic [31:0]     off_mask;

  assign off_mask   = (OffsetBits >= 32) ? 32'hFFFF_FFFF
                                         : ((32'd1 << OffsetBits) - 32'd1);
  assign in_ready_o = ~full;
  // Kind 3 makes no result: drop it at the door.
  assign push = in_valid_i & ~full & (kind_i != bfas_pkg::KIND_IGNORED);

  always_comb begin
    it.kind          = kind_i;
    it.fld_offset    = field_bit_offset_i & off_mask;
    it.fld_count     = field_bit_count_i;
    it.write_value   = write_value_i;
    it.response_data = response_data_i;
    it.response_ok   = response_ok_i;
  end

  bfas_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_item_i(it), .full_o(full),
    .pop_i, .empty_o, .head_o
  );
endmodule

>>> rtl/bfas_back.sv
// Back part: runs the field access sequence into a single output register,
// one item per cycle while that register is not stalled. Depends on bfas_pkg.
module bfas_back #(
  parameter int unsigned MaxFieldBits = bfas_pkg::MaxFieldBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       access_type_i,
  input  logic [1:0]       update_rule_i,
  input  logic [63:0]      region_base_i,
  input  logic             empty_i,
  input  bfas_pkg::item_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bfas_pkg::result_t res_o,
  output logic             idle_o
);
  bfas_pkg::phase_e  phase_q, phase_d;
  logic [6:0]        done_q, done_d;
  logic [63:0]       acc_q, acc_d;
  logic [31:0]       off_q, off_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [63:0]       wv_q, wv_d;
  logic              ov_q;
  bfas_pkg::result_t res_q, res_d;
  logic              emit;

  // Geometry for the step that is about to be taken.
  logic [2:0]  lg;
  logic        bad;
  logic [6:0]  abits;
  logic [32:0] p;
  logic [6:0]  done_s, cnt_s, left, valid, shift, newdone;
  logic [31:0] off_s;
  logic [63:0] wv_s, addr, next_addr, amask, vmask, piece, wdata, base;
  logic [29:0] byte_idx;
  logic        is_req, is_rsp, full_acc, last;

  assign pop_o       = ~empty_i & (~ov_q | out_ready_i);
  assign out_valid_o = ov_q;
  assign res_o       = res_q;
  assign idle_o      = phase_q == bfas_pkg::PH_IDLE;

  always_comb begin
    lg    = bfas_pkg::size_log2(access_type_i);
    bad   = lg == bfas_pkg::SIZE_BAD;
    abits = 7'd8 << lg[1:0];
    amask = bfas_pkg::ones64(abits);
    is_req = head_i.kind == bfas_pkg::KIND_READ_REQ
          || head_i.kind == bfas_pkg::KIND_WRITE_REQ;
    is_rsp = head_i.kind == bfas_pkg::KIND_RESPONSE;
    // Step position: fresh request starts at zero, else after the held run.
    if (is_req) begin
      off_s = head_i.fld_offset; cnt_s = head_i.fld_count[6:0];
      done_s = 7'd0; wv_s = head_i.write_value;
    end else begin
      off_s = off_q; cnt_s = cnt_q; done_s = done_q; wv_s = wv_q;
    end
    p        = {1'b0, off_s} + {26'd0, done_s};
    byte_idx = p[32:3] & ~((30'd1 << lg[1:0]) - 30'd1);
    addr     = region_base_i + {34'd0, byte_idx};
    // A piece that does not end the run fills its access to the top, so the
    // next access is the adjacent aligned one.
    next_addr = addr + (64'd1 << lg[1:0]);
    shift    = {1'b0, p[5:0]} & (abits - 7'd1);
    left     = cnt_s - done_s;
    valid    = (abits - shift < left) ? abits - shift : left;
    vmask    = bfas_pkg::ones64(valid);
    full_acc = valid == abits;
    newdone  = done_s + valid;
    last     = newdone >= cnt_s;
    piece    = ((head_i.response_data & amask) >> shift[5:0]) & vmask;
  end

  // Write data with a given fill base.
  function automatic logic [63:0] mk_write(input logic [63:0] b, input logic [63:0] v,
      input logic [6:0] d, input logic [63:0] vm, input logic [6:0] sh,
      input logic [63:0] am);
    logic [63:0] r;
    begin
      r = b & ~(vm << sh[5:0]);
      r = r | (((v >> d[5:0]) & vm) << sh[5:0]);
      return r & am;
    end
  endfunction

  always_comb begin
    phase_d = phase_q; done_d = done_q; acc_d = acc_q;
    off_d = off_q; cnt_d = cnt_q; wv_d = wv_q;
    res_d = res_q; emit = 1'b0;
    base  = (update_rule_i == bfas_pkg::UR_ONES) ? '1 : '0;
    wdata = '0;
    if (pop_o) begin
      if (is_req) begin
        emit = 1'b1;
        res_d.bus_address = '0; res_d.bus_data = '0;
        if (phase_q != bfas_pkg::PH_IDLE) res_d.result_kind = bfas_pkg::RK_BUSY;
        else if ({24'd0, head_i.fld_count} > MaxFieldBits || bad)
          res_d.result_kind = bfas_pkg::RK_FAILED;
        else if (head_i.fld_count == 8'd0)
          res_d.result_kind = head_i.kind == bfas_pkg::KIND_READ_REQ ?
                              bfas_pkg::RK_READ_DONE : bfas_pkg::RK_WRITE_DONE;
        else begin
          off_d = off_s; cnt_d = cnt_s; wv_d = wv_s; done_d = 7'd0; acc_d = '0;
          res_d.bus_address = addr;
          if (head_i.kind == bfas_pkg::KIND_READ_REQ) begin
            phase_d = bfas_pkg::PH_READ; res_d.result_kind = bfas_pkg::RK_BUS_READ;
          end else if (!full_acc && update_rule_i == bfas_pkg::UR_PRESERVE) begin
            phase_d = bfas_pkg::PH_PRESERVE; res_d.result_kind = bfas_pkg::RK_BUS_READ;
          end else begin
            phase_d = bfas_pkg::PH_WRITE; res_d.result_kind = bfas_pkg::RK_BUS_WRITE;
            res_d.bus_data = mk_write(full_acc ? 64'd0 : base, wv_s, done_s,
                                      vmask, shift, amask);
          end
        end
      end else if (is_rsp && phase_q != bfas_pkg::PH_IDLE) begin
        emit = 1'b1;
        res_d.bus_address = '0; res_d.bus_data = '0;
        if (!head_i.response_ok || bad) begin
          phase_d = bfas_pkg::PH_IDLE; res_d.result_kind = bfas_pkg::RK_FAILED;
        end else begin
          case (phase_q)
            bfas_pkg::PH_READ: begin
              acc_d = acc_q | (piece << done_q[5:0]);
              done_d = newdone;
              if (last) begin
                phase_d = bfas_pkg::PH_IDLE;
                res_d.result_kind = bfas_pkg::RK_READ_DONE; res_d.bus_data = acc_d;
              end else begin
                // Next address is the adjacent aligned access.
                res_d.result_kind = bfas_pkg::RK_BUS_READ;
                res_d.bus_address = next_addr;
              end
            end
            bfas_pkg::PH_PRESERVE: begin
              phase_d = bfas_pkg::PH_WRITE;
              res_d.result_kind = bfas_pkg::RK_BUS_WRITE; res_d.bus_address = addr;
              res_d.bus_data = mk_write(head_i.response_data, wv_q, done_q,
                                        vmask, shift, amask);
            end
            default: begin
              done_d = newdone;
              if (last) begin
                phase_d = bfas_pkg::PH_IDLE; res_d.result_kind = bfas_pkg::RK_WRITE_DONE;
              end else begin
                // Next piece is always aligned at its start: address follows.
                res_d.bus_address = next_addr;
                if (cnt_q - newdone >= abits) begin
                  res_d.result_kind = bfas_pkg::RK_BUS_WRITE;
                  wdata = mk_write(64'd0, wv_q, newdone, amask, 7'd0, amask);
                  res_d.bus_data = wdata;
                end else if (update_rule_i == bfas_pkg::UR_PRESERVE) begin
                  phase_d = bfas_pkg::PH_PRESERVE;
                  res_d.result_kind = bfas_pkg::RK_BUS_READ;
                end else begin
                  res_d.result_kind = bfas_pkg::RK_BUS_WRITE;
                  res_d.bus_data = mk_write(base, wv_q, newdone,
                    bfas_pkg::ones64(cnt_q - newdone), 7'd0, amask);
                end
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bfas_pkg::PH_IDLE;
      ov_q    <= 1'b0;
      done_q  <= '0;
      cnt_q   <= '0;
      off_q   <= '0;
      acc_q   <= '0;
      wv_q    <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      off_q   <= off_d;
      acc_q   <= acc_d;
      wv_q    <= wv_d;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= res_d;
  end
endmodule

>>> tb/sv/tb_bit_field_access_sequencer.sv
`timescale 1ns / 100ps
// Self-checking testbench for bit_field_access_sequencer.
// Depends on bfas_pkg and the block's RTL; runs directed rows, then random
// request/response runs, and checks every result against typed expectations or a predictor.
module tb_bit_field_access_sequencer;
  import bfas_pkg::*;

  // Kind 3 is ignored by the block; give it a name of its own.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         NUM_ROWS    = 22;
  localparam int         NUM_SETUPS  = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [31:0] field_bit_offset_i = '0;
  logic [7:0]  field_bit_count_i = '0;
  logic [63:0] write_value_i = '0;
  logic [63:0] response_data_i = '0;
  logic        response_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [63:0] bus_address_o;
  logic [63:0] bus_data_o;

  bit_field_access_sequencer DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: configuration, run state and the queue of awaited results.
  // ---------------------------------------------------------------------------
  logic [2:0]  acc_type = 3'd1;
  logic [1:0]  upd_rule = 2'd0;
  logic [63:0] region = '0;

  phase_e      run_phase = PH_IDLE;
  int unsigned done_bits = 0;
  logic [63:0] gathered = '0;
  logic [63:0] held_off = '0;
  int unsigned held_cnt = 0;
  logic [63:0] held_wval = '0;

  result_t     awaited_results[$];
  int          mismatches = 0;

  // Idle mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both.
  int          idle_mode = 0;
  logic        stall_req = 1'b0;
  bit          stall_taken = 1'b0;
  int          stall_left = 0;

  function automatic void await_result(input result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic logic [63:0] low_ones(int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Access size in bytes; zero for buffer and undefined types.
  function automatic int unsigned bytes_per_access();
    case (acc_type)
      3'd0, 3'd1: return 1;
      3'd2:       return 2;
      3'd3:       return 4;
      3'd4:       return 8;
      default:    return 0;
    endcase
  endfunction

  function automatic void access_geometry(input int unsigned nbytes,
                                          output logic [63:0] addr,
                                          output int unsigned shift,
                                          output int unsigned width);
    logic [63:0] pos;
    logic [63:0] byte_idx;
    int unsigned left;
    pos      = held_off + 64'(done_bits);
    byte_idx = pos >> 3;
    byte_idx = byte_idx - (byte_idx % nbytes);
    addr     = region + byte_idx;
    shift    = int'(pos % (nbytes * 8));
    width    = nbytes * 8 - shift;
    left     = held_cnt - done_bits;
    if (left < width) width = left;
  endfunction

  function automatic result_t write_piece(int unsigned nbytes, logic [63:0] fill);
    logic [63:0] addr;
    logic [63:0] mask;
    logic [63:0] data;
    int unsigned shift;
    int unsigned width;
    access_geometry(nbytes, addr, shift, width);
    mask = low_ones(width);
    data = fill & ~(mask << shift);
    data |= ((held_wval >> done_bits) & mask) << shift;
    data &= low_ones(nbytes * 8);
    run_phase = PH_WRITE;
    return '{RK_BUS_WRITE, addr, data};
  endfunction

  // Full pieces go straight out; partial ones follow the update rule.
  function automatic result_t begin_write_piece(int unsigned nbytes);
    logic [63:0] addr;
    int unsigned shift;
    int unsigned width;
    access_geometry(nbytes, addr, shift, width);
    if (width == nbytes * 8) return write_piece(nbytes, '0);
    if (upd_rule == UR_PRESERVE) begin
      run_phase = PH_PRESERVE;
      return '{RK_BUS_READ, addr, 64'd0};
    end
    if (upd_rule == UR_ONES) return write_piece(nbytes, '1);
    return write_piece(nbytes, '0);
  endfunction

  // Advance the predicted state by one accepted item; return 1 with a result.
  function automatic bit field_access_step(input logic [1:0] kind,
                                           input logic [31:0] off,
                                           input logic [7:0] cnt,
                                           input logic [63:0] wval,
                                           input logic [63:0] rdata,
                                           input logic ok,
                                           output result_t res);
    int unsigned nbytes;
    logic [63:0] addr;
    logic [63:0] piece;
    int unsigned shift;
    int unsigned width;
    nbytes = bytes_per_access();
    res = '0;
    if (kind == KIND_READ_REQ || kind == KIND_WRITE_REQ) begin
      if (run_phase != PH_IDLE) begin
        res.result_kind = RK_BUSY;
        return 1'b1;
      end
      if (cnt > 8'd64 || nbytes == 0) begin
        res.result_kind = RK_FAILED;
        return 1'b1;
      end
      if (cnt == 8'd0) begin
        res.result_kind = (kind == KIND_READ_REQ) ? RK_READ_DONE : RK_WRITE_DONE;
        return 1'b1;
      end
      held_off  = 64'(off);
      held_cnt  = cnt;
      held_wval = wval;
      done_bits = 0;
      gathered  = '0;
      if (kind == KIND_WRITE_REQ) begin
        res = begin_write_piece(nbytes);
        return 1'b1;
      end
      access_geometry(nbytes, addr, shift, width);
      run_phase = PH_READ;
      res = '{RK_BUS_READ, addr, 64'd0};
      return 1'b1;
    end
    if (kind != KIND_RESPONSE || run_phase == PH_IDLE) return 1'b0;
    if (!ok || nbytes == 0) begin
      run_phase = PH_IDLE;
      res.result_kind = RK_FAILED;
      return 1'b1;
    end
    access_geometry(nbytes, addr, shift, width);
    if (run_phase == PH_READ) begin
      piece = ((rdata & low_ones(nbytes * 8)) >> shift) & low_ones(width);
      gathered |= piece << done_bits;
      done_bits += width;
      if (done_bits >= held_cnt) begin
        run_phase = PH_IDLE;
        res = '{RK_READ_DONE, 64'd0, gathered};
        return 1'b1;
      end
      access_geometry(nbytes, addr, shift, width);
      res = '{RK_BUS_READ, addr, 64'd0};
      return 1'b1;
    end
    if (run_phase == PH_PRESERVE) begin
      res = write_piece(nbytes, rdata);
      return 1'b1;
    end
    done_bits += width;
    if (done_bits >= held_cnt) begin
      run_phase = PH_IDLE;
      res.result_kind = RK_WRITE_DONE;
      return 1'b1;
    end
    res = begin_write_piece(nbytes);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Called at a rising edge; returns at the edge of acceptance.
  // ---------------------------------------------------------------------------
  task automatic offer_item(input logic [1:0] kind, input logic [31:0] off,
                            input logic [7:0] cnt, input logic [63:0] wval,
                            input logic [63:0] rdata, input logic ok);
    while ((idle_mode == 1 && $urandom_range(99) < 52) ||
           (idle_mode == 3 && $urandom_range(99) < 25)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    kind_i             <= kind;
    field_bit_offset_i <= off;
    field_bit_count_i  <= cnt;
    write_value_i      <= wval;
    response_data_i    <= rdata;
    response_ok_i      <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ACCESS_TYPE: acc_type = val[2:0];
      REG_UPDATE_RULE: upd_rule = val[1:0];
      default:         region   = val;
    endcase
  endtask

  // Drain all awaited results, then give the block its latency to settle
  // from items that cause no result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_req && !stall_taken) begin
      stall_left = 80;
      stall_taken = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready_i <= ($urandom_range(99) >= 52);
    end else if (idle_mode == 3) begin
      out_ready_i <= ($urandom_range(99) >= 25);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest awaited one.
  always @(posedge clk_i) begin : check_results
    result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d addr %h data %h",
               result_kind_o, bus_address_o, bus_data_o);
        mismatches++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (result_kind_o !== exp_res.result_kind) begin
          $error("result_kind: expected %0d, got %0d", exp_res.result_kind, result_kind_o);
          mismatches++;
        end
        if (bus_address_o !== exp_res.bus_address) begin
          $error("bus_address: expected %h, got %h", exp_res.bus_address, bus_address_o);
          mismatches++;
        end
        if (bus_data_o !== exp_res.bus_data) begin
          $error("bus_data: expected %h, got %h", exp_res.bus_data, bus_data_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows: typed expectations where they are obvious, else predicted.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] off;
    logic [7:0]  cnt;
    logic [63:0] wval;
    logic [63:0] rdata;
    logic        ok;
    bit          typed;
    bit          has_res;
    result_t     res;
  } dir_row_t;

  dir_row_t dir_rows[NUM_ROWS];

  typedef struct {
    logic [2:0]  at;
    logic [1:0]  ur;
    logic [63:0] base;
    int          items;
  } setup_t;

  setup_t setups[NUM_SETUPS];

  initial begin
    result_t     pred;
    bit          got;
    logic [1:0]  kind;
    logic [31:0] off;
    logic [7:0]  cnt;
    logic [63:0] rdata;
    logic        ok;
    int          pick;

    // Byte access after reset, update rule preserve, base zero.
    dir_rows[0]  = '{KIND_READ_REQ, 0, 0, 0, 0, 1, 1, 1, '{RK_READ_DONE, 0, 0}};
    dir_rows[1]  = '{KIND_WRITE_REQ, 0, 0, '1, 0, 1, 1, 1, '{RK_WRITE_DONE, 0, 0}};
    dir_rows[2]  = '{KIND_READ_REQ, 5, 65, 0, 0, 1, 1, 1, '{RK_FAILED, 0, 0}};
    dir_rows[3]  = '{KIND_WRITE_REQ, '1, 255, '1, '1, 1, 1, 1, '{RK_FAILED, 0, 0}};
    dir_rows[4]  = '{KIND_RESPONSE, '1, '1, '1, '1, 1, 1, 0, '0};
    dir_rows[5]  = '{KIND_UNUSED, '1, '1, '1, '1, 1, 1, 0, '0};
    dir_rows[6]  = '{KIND_READ_REQ, 0, 8, 0, 0, 1, 1, 1, '{RK_BUS_READ, 0, 0}};
    dir_rows[7]  = '{KIND_WRITE_REQ, 0, 8, 0, 0, 1, 1, 1, '{RK_BUSY, 0, 0}};
    dir_rows[8]  = '{KIND_RESPONSE, 0, 0, 0, 64'hA5, 1, 1, 1, '{RK_READ_DONE, 0, 64'hA5}};
    // Unaligned write: preserve reads on both partial bytes.
    dir_rows[9]  = '{KIND_WRITE_REQ, 4, 8, '1, 0, 1, 0, 0, '0};
    dir_rows[10] = '{KIND_RESPONSE, 0, 0, 0, 0, 1, 0, 0, '0};
    dir_rows[11] = '{KIND_RESPONSE, 0, 0, 0, '1, 1, 0, 0, '0};
    dir_rows[12] = '{KIND_RESPONSE, 0, 0, 0, '1, 1, 0, 0, '0};
    dir_rows[13] = '{KIND_RESPONSE, 0, 0, 0, 0, 1, 0, 0, '0};
    // Highest offset, full width, then a failed bus access.
    dir_rows[14] = '{KIND_READ_REQ, '1, 64, 0, 0, 1, 0, 0, '0};
    dir_rows[15] = '{KIND_RESPONSE, 0, 0, 0, '1, 0, 1, 1, '{RK_FAILED, 0, 0}};
    dir_rows[16] = '{KIND_READ_REQ, 3, 64, 0, 0, 1, 0, 0, '0};
    dir_rows[17] = '{KIND_UNUSED, 0, 0, 0, 0, 1, 1, 0, '0};
    dir_rows[18] = '{KIND_RESPONSE, 0, 0, 0, 64'h0123_4567_89AB_CDEF, 1, 0, 0, '0};
    dir_rows[19] = '{KIND_RESPONSE, 0, 0, 0, '1, 1, 0, 0, '0};
    dir_rows[20] = '{KIND_RESPONSE, 0, 0, 0, 64'h5A, 1, 0, 0, '0};
    dir_rows[21] = '{KIND_RESPONSE, 0, 0, 0, 0, 0, 0, 0, '0};

    setups[0] = '{3'd1, 2'd0, 64'd0, 100};
    setups[1] = '{3'd0, 2'd1, '1, 80};
    setups[2] = '{3'd2, 2'd2, {$urandom, $urandom}, 100};
    setups[3] = '{3'd3, 2'd3, {$urandom, $urandom}, 100};
    setups[4] = '{3'd4, 2'd0, 64'hFFFF_FFFF_FFFF_FFF0, 100};
    setups[5] = '{3'd4, 2'd1, 64'd0, 80};
    setups[6] = '{3'd5, 2'd0, {$urandom, $urandom}, 30};
    setups[7] = '{3'd7, 2'd2, {$urandom, $urandom}, 30};
    setups[8] = '{3'd3, 2'd0, {$urandom, $urandom}, 100};
    setups[9] = '{3'd2, 2'd0, '1, 80};

    // Hold reset, then walk the directed rows with no idling.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].kind, dir_rows[i].off, dir_rows[i].cnt,
                 dir_rows[i].wval, dir_rows[i].rdata, dir_rows[i].ok);
      got = field_access_step(dir_rows[i].kind, dir_rows[i].off, dir_rows[i].cnt,
                              dir_rows[i].wval, dir_rows[i].rdata, dir_rows[i].ok, pred);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].has_res) await_result(dir_rows[i].res);
      end else if (got) begin
        await_result(pred);
      end
    end

    // Random part: one setup per phase, cycling through the idling modes.
    for (int s = 0; s < NUM_SETUPS; s++) begin
      // Finish any run left open, so register writes land while idle.
      while (run_phase != PH_IDLE) begin
        offer_item(KIND_RESPONSE, 0, 0, 0, {$urandom, $urandom}, 1'b0);
        got = field_access_step(KIND_RESPONSE, 0, 0, 0, 0, 1'b0, pred);
        if (got) await_result(pred);
      end
      wait_drained();
      idle_mode = s % 4;
      write_reg(REG_ACCESS_TYPE, {$urandom, 29'($urandom), setups[s].at});
      write_reg(REG_UPDATE_RULE, {$urandom, 30'($urandom), setups[s].ur});
      write_reg(REG_REGION_BASE, setups[s].base);
      cfg_valid_i <= 1'b0;
      // Long receiver hold-off while the sender keeps pushing.
      if (s == 2) stall_req <= 1'b1;

      for (int n = 0; n < setups[s].items; n++) begin
        pick  = $urandom_range(99);
        off   = (pick < 70) ? 32'($urandom_range(0, 255)) : $urandom;
        cnt   = ($urandom_range(99) < 85) ? 8'($urandom_range(1, 64)) : 8'($urandom);
        rdata = {$urandom, $urandom};
        ok    = 1'b1;
        if (run_phase == PH_IDLE) begin
          // Mostly start a new run; sometimes a stray response or kind 3.
          kind = (pick < 80) ? 2'($urandom_range(0, 1)) :
                 (pick < 92) ? KIND_RESPONSE : KIND_UNUSED;
          ok   = ($urandom_range(1) == 1);
        end else begin
          kind = (pick < 87) ? KIND_RESPONSE :
                 (pick < 94) ? 2'($urandom_range(0, 1)) : KIND_UNUSED;
          if (kind == KIND_RESPONSE && $urandom_range(99) < 5) ok = 1'b0;
        end
        offer_item(kind, off, cnt, {$urandom, $urandom}, rdata, ok);
        got = field_access_step(kind, off, cnt, write_value_i, rdata, ok, pred);
        if (got) await_result(pred);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> bit_field_access_sequencer.f
rtl/bfas_pkg.sv
rtl/bfas_queue.sv
rtl/bfas_front.sv
rtl/bfas_back.sv
rtl/bit_field_access_sequencer.sv
tb/sv/tb_bit_field_access_sequencer.sv
